/* rtl/kdcs_pkg.sv */
// Shared types, constants and register indexes for the key difference column sum block.
`default_nettype none
package kdcs_pkg;

  localparam int MAX_KEY_BITS  = 256;
  localparam int MAX_ROWS      = 16;
  localparam int KEY_WORD_BITS = 32;
  localparam int WORD_SLOTS    = (MAX_KEY_BITS + KEY_WORD_BITS - 1) / KEY_WORD_BITS;

  localparam int COL_W   = $clog2(MAX_KEY_BITS);
  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int BIT_W   = $clog2(KEY_WORD_BITS);
  localparam int WPOS_W  = (WORD_SLOTS > 1) ? $clog2(WORD_SLOTS) : 1;
  localparam int GBIT_W  = WPOS_W + BIT_W;
  localparam int KBC_W   = 9;
  localparam int RC_W    = 5;
  localparam int WGT_W   = 16;
  localparam int SUM_W   = 32;
  localparam int CFG_W   = 9;
  localparam int CFG_IDX_W = 1;
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_BIT_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT     = 1'd1;

  // Request kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_KEY  = 1'b1;

  typedef struct packed {
    logic                    kind;
    logic [3:0]              weight_row;
    logic [7:0]              weight_col;
    logic signed [WGT_W-1:0] weight_value;
    logic [31:0]             key_left;
    logic [31:0]             key_right;
    logic                    last_word;
  } in_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] row_sum;
    logic [3:0]              row_index;
    logic                    sum_saturated;
    logic                    last_row;
  } out_t;

  // Classified request handed from the front end to the back end
  typedef struct packed {
    logic                     is_key;
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         col;
    logic signed [WGT_W-1:0]  value;
    logic [KEY_WORD_BITS-1:0] diff;
    logic                     last_word;
  } work_t;

endpackage
`default_nettype wire

/* rtl/key_difference_column_sum_core.sv */
// Top level of the key difference column sum block: config registers, front end, back end.
//
// Weighted Hamming distance between two keys. Load requests (kind 0) write one signed Q8.8
// weight into a 16-row by 256-column store. Key requests (kind 1) carry one 32-bit word of
// each key; the back end walks the word one bit per cycle, reading one weight column for
// all rows at once and adding it into every active row's saturating Q24.8 accumulator where
// the keys differ, so a key word passes through a pop, the bit steps and one drain for the
// registered column read. On the word marked last, one result per active row follows at one
// per cycle while the output is taken. A two-entry request queue lets the input side run
// ahead of the back end. The user must write configuration through cfg_we / cfg_index /
// cfg_data only while no query is in flight; the block does not enforce this.
`default_nettype none
module key_difference_column_sum_core
  import kdcs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_t                  in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_t                      out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  logic [KBC_W-1:0] key_bit_count;
  logic [RC_W-1:0]  row_count;
  logic             q_valid;
  work_t            q_head;
  logic             q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_bit_count <= KBC_W'(256);
      row_count     <= RC_W'(16);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_BIT_COUNT: key_bit_count <= cfg_data[KBC_W-1:0];
        REG_ROW_COUNT:     row_count     <= cfg_data[RC_W-1:0];
        default:           row_count     <= row_count;
      endcase
    end
  end

  kdcs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  kdcs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .key_bit_count (key_bit_count),
    .row_count     (row_count),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data)
  );

endmodule
`default_nettype wire

/* rtl/kdcs_ram.sv */
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module kdcs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* rtl/kdcs_front.sv */
// Front end: accepts requests, classifies them and queues them for the back end.
`default_nettype none
module kdcs_front
  import kdcs_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire in_t   in_data,
  output logic       q_valid,
  output work_t      q_head,
  input  wire logic  q_pop
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  work_t              slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  work_t              classified;
  logic               push;
  logic               pop;

  always_comb begin
    classified.is_key    = (in_data.kind == KIND_KEY);
    classified.row       = ROW_W'(in_data.weight_row);
    classified.col       = COL_W'(in_data.weight_col);
    classified.value     = in_data.weight_value;
    classified.diff      = in_data.key_left ^ in_data.key_right;
    classified.last_word = in_data.last_word;
  end

  assign in_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != '0);
  assign pop      = q_pop && q_valid;
  assign q_head   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/kdcs_back.sv */
// Back end: weight store, bit-serial column scan, row accumulators and result output.
`default_nettype none
module kdcs_back
  import kdcs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_valid,
  input  wire work_t            q_head,
  output logic                  q_pop,
  input  wire logic [KBC_W-1:0] key_bit_count,
  input  wire logic [RC_W-1:0]  row_count,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_t                  out_data
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]               state;
  logic [KEY_WORD_BITS-1:0] diff_sh;
  logic [BIT_W-1:0]         bit_idx;
  logic [WPOS_W-1:0]        word_pos;
  logic                     last_q;
  logic                     add_q;
  logic [ROW_W-1:0]         emit_row;

  logic signed [SUM_W-1:0]  acc [MAX_ROWS];
  logic [MAX_ROWS-1:0]      sat;
  logic [WGT_W-1:0]         rd_data [MAX_ROWS];
  logic signed [SUM_W-1:0]  acc_sum [MAX_ROWS];
  logic [MAX_ROWS-1:0]      acc_ovf;

  logic [KBC_W-1:0]         bits_act;
  logic [RC_W-1:0]          rows_act;
  logic [GBIT_W-1:0]        gbit;
  logic                     rd_en;
  logic                     load_we;
  logic                     emit_go;
  logic                     emit_last;

  assign bits_act = (key_bit_count > KBC_W'(MAX_KEY_BITS)) ? KBC_W'(MAX_KEY_BITS)
                                                           : key_bit_count;
  assign rows_act = (row_count > RC_W'(MAX_ROWS)) ? RC_W'(MAX_ROWS) : row_count;

  assign gbit  = {word_pos, bit_idx};
  assign rd_en = (state == ST_SCAN) && diff_sh[KEY_WORD_BITS-1]
                 && (KBC_W'(gbit) < bits_act);

  assign q_pop   = (state == ST_IDLE) && q_valid;
  assign load_we = q_pop && !q_head.is_key;

  assign emit_go   = (state == ST_EMIT) && (!out_valid || out_ready);
  assign emit_last = (RC_W'(emit_row) + RC_W'(1) == rows_act);

  // One RAM per row: all rows of a column come out in one read
  for (genvar r = 0; r < MAX_ROWS; r++) begin : g_row
    kdcs_ram #(
      .WIDTH (WGT_W),
      .DEPTH (MAX_KEY_BITS)
    ) u_ram (
      .clk   (clk),
      .we    (load_we && (q_head.row == ROW_W'(r))),
      .waddr (q_head.col),
      .wdata (q_head.value),
      .re    (rd_en),
      .raddr (COL_W'(gbit)),
      .rdata (rd_data[r])
    );

    logic signed [SUM_W:0] wide;
    always_comb begin
      wide = {acc[r][SUM_W-1], acc[r]}
             + (SUM_W + 1)'($signed(rd_data[r]));
      acc_ovf[r] = (wide[SUM_W] != wide[SUM_W-1]);
      if (acc_ovf[r]) begin
        // clamp toward the sign of the true result
        acc_sum[r] = wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
        acc_sum[r] = wide[SUM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      bit_idx  <= '0;
      word_pos <= '0;
      last_q   <= 1'b0;
      add_q    <= 1'b0;
      emit_row <= '0;
      out_valid <= 1'b0;
      sat      <= '0;
      for (int r = 0; r < MAX_ROWS; r++) begin
        acc[r] <= '0;
      end
    end else begin
      add_q <= rd_en;
      if (add_q) begin
        for (int r = 0; r < MAX_ROWS; r++) begin
          if (RC_W'(r) < rows_act) begin
            acc[r] <= acc_sum[r];
            if (acc_ovf[r]) begin
              sat[r] <= 1'b1;
            end
          end
        end
      end

      // drop the result once taken unless a new one replaces it
      if (out_valid && out_ready && !(emit_go && (rows_act != '0))) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (q_pop && q_head.is_key) begin
            bit_idx <= '0;
            last_q  <= q_head.last_word;
            state   <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          bit_idx <= bit_idx + BIT_W'(1);
          if (bit_idx == BIT_W'(KEY_WORD_BITS - 1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          // last column add lands this cycle
          if (last_q) begin
            word_pos <= '0;
            emit_row <= '0;
            state    <= ST_EMIT;
          end else begin
            word_pos <= (word_pos == WPOS_W'(WORD_SLOTS - 1)) ? '0 : word_pos + WPOS_W'(1);
            state    <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (rows_act == '0) begin
            sat   <= '0;
            for (int r = 0; r < MAX_ROWS; r++) begin
              acc[r] <= '0;
            end
            state <= ST_IDLE;
          end else if (emit_go) begin
            out_valid <= 1'b1;
            emit_row  <= emit_row + ROW_W'(1);
            if (emit_last) begin
              sat   <= '0;
              for (int r = 0; r < MAX_ROWS; r++) begin
                acc[r] <= '0;
              end
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Shift the difference word so the bit under test is always the top one
  always_ff @(posedge clk) begin
    if (q_pop && q_head.is_key) begin
      diff_sh <= q_head.diff;
    end else if (state == ST_SCAN) begin
      diff_sh <= diff_sh << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go && (rows_act != '0)) begin
      out_data.row_sum       <= acc[emit_row];
      out_data.row_index     <= 4'(emit_row);
      out_data.sum_saturated <= sat[emit_row];
      out_data.last_row      <= emit_last;
    end
  end

endmodule
`default_nettype wire
